[hdl/bouncing_eye_scanner_top_assert.svh]
// Assertion macros for the bouncing eye scanner top level.
`ifndef BOUNCING_EYE_SCANNER_TOP_ASSERT_SVH
`define BOUNCING_EYE_SCANNER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside of reset.
`define BES_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bouncing eye scanner: implication check failed");
// Next-cycle implication, checked outside of reset.
`define BES_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bouncing eye scanner: next-cycle check failed");
`else
`define BES_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define BES_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[hdl/bes_pkg.sv]
// Shared types and constants for the bouncing eye scanner.
package bes_pkg;

    // Field widths.
    localparam int unsigned IdxW   = 6;
    localparam int unsigned ColorW = 8;
    localparam int unsigned WaitW  = 9;
    localparam int unsigned CfgIdxW = 3;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] RegHue        = 3'd0;
    localparam logic [CfgIdxW-1:0] RegSaturation = 3'd1;
    localparam logic [CfgIdxW-1:0] RegBrightness = 3'd2;
    localparam logic [CfgIdxW-1:0] RegEyeSize    = 3'd3;
    localparam logic [CfgIdxW-1:0] RegStepDelay  = 3'd4;
    localparam logic [CfgIdxW-1:0] RegTurnDelay  = 3'd5;

    // Reciprocal of five for 8-bit values: floor(x / 5) == (x * 205) >> 10.
    localparam logic [7:0] RecipFive = 8'd205;
    localparam int unsigned RecipShift = 10;

    // Configuration write as seen by the front end.
    typedef struct packed {
        logic                wr;
        logic [CfgIdxW-1:0]  index;
        logic [ColorW-1:0]   data;
    } t_cfg_wr;

    // One frame to be drawn by the back end.
    typedef struct packed {
        logic [IdxW-1:0]   first;    // left dim pixel
        logic [IdxW-1:0]   last;     // right dim pixel
        logic [ColorW-1:0] hue;
        logic [ColorW-1:0] sat;
        logic [ColorW-1:0] bright;
        logic [ColorW-1:0] dim;
    } t_frame_desc;

    // Frame queue status.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[hdl/bes_front.sv]
// Front end: holds configuration, counts ticks and schedules frames.
module bes_front
    import bes_pkg::*;
#(
    parameter int unsigned LED_COUNT = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg_wr             i_cfg,
    input  logic                i_take,
    input  logic                i_tick,
    output logic                o_push_desc,
    output t_frame_desc         o_desc
);

    localparam logic [IdxW-1:0] MaxSize  = IdxW'(LED_COUNT - 3);
    localparam logic [IdxW:0]   LedCount = (IdxW+1)'(LED_COUNT);

    logic [ColorW-1:0] r_hue, r_sat, r_bright, r_step, r_turn;
    logic [IdxW-1:0]   r_eye_size;
    logic [IdxW-1:0]   r_pos;
    logic              r_left;
    logic              r_first;
    logic [WaitW-1:0]  r_wait;

    logic              w_fire;
    logic [IdxW-1:0]   w_size, w_top, w_raw, w_pos, n_pos;
    logic              w_left, w_last;
    logic [WaitW-1:0]  w_sum, n_wait;
    logic [15:0]       w_prod;

    // A frame is due on a real tick once the wait count has run out.
    assign w_fire = i_take && i_tick && (r_wait == '0);

    // Eye geometry and position for this frame.
    always_comb begin
        w_size = (r_eye_size > MaxSize) ? MaxSize : r_eye_size;
        w_top  = IdxW'(LedCount - {1'b0, w_size} - (IdxW+1)'(2));
        w_left = r_first ? 1'b1 : r_left;
        w_raw  = r_first ? w_top : r_pos;
        if (w_left) begin
            w_pos  = (w_raw > w_top) ? w_top : w_raw;
            if (w_pos == '0) begin
                w_pos = IdxW'(1);
            end
            w_last = (w_pos == IdxW'(1));
            n_pos  = w_last ? '0 : w_pos - IdxW'(1);
        end else begin
            w_pos  = (w_raw > w_top - IdxW'(1)) ? w_top - IdxW'(1) : w_raw;
            w_last = (w_pos == w_top - IdxW'(1));
            n_pos  = w_last ? w_top : w_pos + IdxW'(1);
        end
    end

    // Wait count until the next frame.
    always_comb begin
        w_sum  = {1'b0, r_step} + (w_last ? {1'b0, r_turn} : '0);
        n_wait = (w_sum == '0) ? '0 : w_sum - WaitW'(1);
    end

    // Edge brightness is one fifth of the core, by reciprocal multiply.
    assign w_prod = {8'd0, r_bright} * {8'd0, RecipFive};

    // Frame descriptor handed to the queue.
    always_comb begin
        o_push_desc   = w_fire;
        o_desc.first  = w_pos;
        o_desc.last   = w_pos + w_size + IdxW'(1);
        o_desc.hue    = r_hue;
        o_desc.sat    = r_sat;
        o_desc.bright = r_bright;
        o_desc.dim    = ColorW'(w_prod >> RecipShift);
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue      <= 8'd0;
            r_sat      <= 8'd255;
            r_bright   <= 8'd255;
            r_eye_size <= 6'd3;
            r_step     <= 8'd50;
            r_turn     <= 8'd50;
        end else if (i_cfg.wr) begin
            case (i_cfg.index)
                RegHue:        r_hue      <= i_cfg.data;
                RegSaturation: r_sat      <= i_cfg.data;
                RegBrightness: r_bright   <= i_cfg.data;
                RegEyeSize:    r_eye_size <= i_cfg.data[IdxW-1:0];
                RegStepDelay:  r_step     <= i_cfg.data;
                RegTurnDelay:  r_turn     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Sweep state and tick counting.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_left  <= 1'b1;
            r_first <= 1'b1;
            r_wait  <= '0;
        end else if (i_take && i_tick) begin
            if (r_wait != '0) begin
                r_wait <= r_wait - WaitW'(1);
            end else begin
                r_first <= 1'b0;
                r_left  <= w_left ^ w_last;
                r_pos   <= n_pos;
                r_wait  <= n_wait;
            end
        end
    end

endmodule

[hdl/bes_desc_fifo.sv]
// Two-entry queue of frame descriptors between front and back end.
module bes_desc_fifo
    import bes_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  t_frame_desc  i_wr_data,
    input  logic         i_rd,
    output t_frame_desc  o_rd_data,
    output t_q_status    o_status
);

    t_frame_desc r_mem [2];
    logic        r_wr_ptr, r_rd_ptr;
    logic [1:0]  r_count;
    logic        w_wr, w_rd;

    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);
    assign w_wr = i_wr && !o_status.full;
    assign w_rd = i_rd && !o_status.empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

endmodule

[hdl/bes_back.sv]
// Back end: expands one frame descriptor into pixels, one per cycle unless the output stalls.
module bes_back
    import bes_pkg::*;
#(
    parameter int unsigned LED_COUNT = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_frame_desc        i_desc,
    input  t_q_status          i_q,
    output logic               o_q_rd,
    input  logic               i_pop,
    output logic               o_valid,
    output logic [IdxW-1:0]    o_index,
    output logic [ColorW-1:0]  o_hue,
    output logic [ColorW-1:0]  o_sat,
    output logic [ColorW-1:0]  o_bright,
    output logic               o_frame_end
);

    localparam logic [IdxW-1:0] LastIdx = IdxW'(LED_COUNT - 1);

    t_frame_desc r_desc;
    logic        r_busy;
    logic [IdxW-1:0] r_idx;
    logic        r_out_valid;
    logic [IdxW-1:0] r_out_idx;
    logic [ColorW-1:0] r_out_hue, r_out_sat, r_out_bright;
    logic        r_out_end;

    logic        w_adv, w_done, w_edge, w_core;

    // The output register moves when it is empty or being taken.
    assign w_adv  = !r_out_valid || i_pop;
    assign w_done = r_busy && w_adv && (r_idx == LastIdx);
    assign o_q_rd = (!r_busy || w_done) && !i_q.empty;

    // Classify the current pixel against the eye.
    assign w_edge = (r_idx == r_desc.first) || (r_idx == r_desc.last);
    assign w_core = (r_idx > r_desc.first) && (r_idx < r_desc.last);

    // Frame sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_q_rd) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end else if (r_busy && w_adv) begin
            r_idx <= r_idx + IdxW'(1);
        end
    end

    // Current descriptor.
    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_desc <= i_desc;
        end
    end

    // Output register valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_busy;
        end
    end

    // Output pixel payload.
    always_ff @(posedge i_clk) begin
        if (w_adv && r_busy) begin
            r_out_idx <= r_idx;
            r_out_end <= (r_idx == LastIdx);
            if (w_edge) begin
                r_out_hue    <= r_desc.hue;
                r_out_sat    <= r_desc.sat;
                r_out_bright <= r_desc.dim;
            end else if (w_core) begin
                r_out_hue    <= r_desc.hue;
                r_out_sat    <= r_desc.sat;
                r_out_bright <= r_desc.bright;
            end else begin
                r_out_hue    <= '0;
                r_out_sat    <= '0;
                r_out_bright <= '0;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_index     = r_out_idx;
    assign o_hue       = r_out_hue;
    assign o_sat       = r_out_sat;
    assign o_bright    = r_out_bright;
    assign o_frame_end = r_out_end;

endmodule

[hdl/bouncing_eye_scanner_top.sv]
// Bouncing eye scanner: a frame tick yields LED_COUNT pixels, one per cycle while pop is held.
// A frame is queued, loaded by the back end's sequencer, then sent from its output register.
// Throughput: one tick per cycle while the two-entry frame queue has room; each frame then
// steps the back end's pixel counter through LED_COUNT pixels, which sets the sustained rate.
// Reset is synchronous, active low, and gives the power-on register values with no clearing pass.
`include "bouncing_eye_scanner_top_assert.svh"
module bouncing_eye_scanner_top
    import bes_pkg::*;
#(
    parameter int unsigned LED_COUNT = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  logic                i_tick,
    output logic                empty,
    input  logic                pop,
    output logic [IdxW-1:0]     o_pixel_index,
    output logic [ColorW-1:0]   o_pixel_hue,
    output logic [ColorW-1:0]   o_pixel_saturation,
    output logic [ColorW-1:0]   o_pixel_brightness,
    output logic                o_frame_end,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CfgIdxW-1:0]  i_cfg_index,
    input  logic [ColorW-1:0]   i_cfg_data
);

    t_cfg_wr     w_cfg;
    t_frame_desc w_desc_in, w_desc_out;
    t_q_status   w_q;
    logic        w_take, w_push_desc, w_q_rd, w_valid;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;
    assign w_cfg.wr    = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    // A tick transfer needs room for a frame in the queue.
    assign full   = w_q.full;
    assign w_take = push && !full;
    assign empty  = !w_valid;

    bes_front #(.LED_COUNT(LED_COUNT)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_take      (w_take),
        .i_tick      (i_tick),
        .o_push_desc (w_push_desc),
        .o_desc      (w_desc_in)
    );

    bes_desc_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_push_desc),
        .i_wr_data (w_desc_in),
        .i_rd      (w_q_rd),
        .o_rd_data (w_desc_out),
        .o_status  (w_q)
    );

    bes_back #(.LED_COUNT(LED_COUNT)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_desc      (w_desc_out),
        .i_q         (w_q),
        .o_q_rd      (w_q_rd),
        .i_pop       (pop),
        .o_valid     (w_valid),
        .o_index     (o_pixel_index),
        .o_hue       (o_pixel_hue),
        .o_sat       (o_pixel_saturation),
        .o_bright    (o_pixel_brightness),
        .o_frame_end (o_frame_end)
    );

    // The front end never schedules a frame into a full queue.
    `BES_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, w_push_desc, !w_q.full)
    // The frame end marker sits on the last pixel only.
    `BES_ASSERT_IMPL(a_frame_end_last, i_clk, i_rst_n, !empty && o_frame_end,
                     o_pixel_index == IdxW'(LED_COUNT - 1))
    // Pixels within a frame come out in index order.
    `BES_ASSERT_NEXT(a_index_order, i_clk, i_rst_n, !empty && pop && !o_frame_end,
                     empty || (o_pixel_index == $past(o_pixel_index) + IdxW'(1)))

endmodule

[sim/bouncing_eye_scanner_top_test.sv]
// Self-checking testbench for the bouncing eye scanner: directed table, then random sweeps.
`timescale 1ns / 1ps
module bouncing_eye_scanner_top_test;
    import bes_pkg::*;

    localparam int unsigned LedCount     = 32;
    localparam int unsigned SettleCycles = 8;
    localparam int unsigned HoldCycles   = 300;
    localparam int unsigned TailCycles   = 40;
    localparam int unsigned RandTicks    = 400;
    localparam int unsigned RandFrames   = 60;
    localparam int unsigned IdlePct      = 22;
    localparam int unsigned PrintCap     = 40;

    // Register slots that the block decodes as unused.
    localparam logic [CfgIdxW-1:0] RegSpareLow  = 3'd6;
    localparam logic [CfgIdxW-1:0] RegSpareHigh = 3'd7;

    typedef struct packed {
        logic [IdxW-1:0]   index;
        logic [ColorW-1:0] hue;
        logic [ColorW-1:0] sat;
        logic [ColorW-1:0] bright;
        logic              frame_last;
    } t_pixel;

    typedef enum bit {RowTick, RowCfg} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [CfgIdxW-1:0] reg_idx;
        logic [7:0]         reg_data;
        logic               tick;
        bit                 typed;      // expectation given in the row itself
        bit                 has_frame;
        int unsigned        first;      // left dim pixel of the typed frame
        int unsigned        eye_len;
    } t_plan_row;

    localparam int unsigned NumRows = 24;

    // Directed sequence; typed rows carry the frame as read off the spec.
    t_plan_row plan [NumRows] = '{
        '{RowCfg,  RegStepDelay, 8'd0,   1'b0, 1'b0, 1'b0, 0,  0},
        '{RowCfg,  RegTurnDelay, 8'd0,   1'b0, 1'b0, 1'b0, 0,  0},
        '{RowTick, RegHue,       8'd0,   1'b0, 1'b1, 1'b0, 0,  0},
        '{RowTick, RegHue,       8'd0,   1'b1, 1'b1, 1'b1, 27, 3},
        '{RowTick, RegHue,       8'd0,   1'b1, 1'b1, 1'b1, 26, 3},
        '{RowTick, RegHue,       8'd0,   1'b0, 1'b1, 1'b0, 0,  0},
        '{RowTick, RegHue,       8'd0,   1'b1, 1'b1, 1'b1, 25, 3},
        '{RowCfg,  RegEyeSize,   8'd63,  1'b0, 1'b0, 1'b0, 0,  0},
        '{RowTick, RegHue,       8'd0,   1'b1, 1'b0, 1'b0, 0,  0},
        '{RowTick, RegHue,       8'd0,   1'b1, 1'b0, 1'b0, 0,  0},
        '{RowCfg,  RegHue,       8'd255, 1'b0, 1'b0, 1'b0, 0,  0},
        '{RowCfg,  RegSaturation, 8'd0,  1'b0, 1'b0, 1'b0, 0,  0},
        '{RowCfg,  RegBrightness, 8'd4,  1'b0, 1'b0, 1'b0, 0,  0},
        '{RowCfg,  RegEyeSize,   8'd0,   1'b0, 1'b0, 1'b0, 0,  0},
        '{RowTick, RegHue,       8'd0,   1'b1, 1'b0, 1'b0, 0,  0},
        '{RowTick, RegHue,       8'd0,   1'b1, 1'b0, 1'b0, 0,  0},
        '{RowCfg,  RegSpareLow,  8'd255, 1'b0, 1'b0, 1'b0, 0,  0},
        '{RowCfg,  RegSpareHigh, 8'd0,   1'b0, 1'b0, 1'b0, 0,  0},
        '{RowCfg,  RegEyeSize,   8'd61,  1'b0, 1'b0, 1'b0, 0,  0},
        '{RowCfg,  RegStepDelay, 8'd255, 1'b0, 1'b0, 1'b0, 0,  0},
        '{RowCfg,  RegTurnDelay, 8'd255, 1'b0, 1'b0, 1'b0, 0,  0},
        '{RowTick, RegHue,       8'd0,   1'b1, 1'b0, 1'b0, 0,  0},
        '{RowTick, RegHue,       8'd0,   1'b1, 1'b0, 1'b0, 0,  0},
        '{RowTick, RegHue,       8'd0,   1'b0, 1'b0, 1'b0, 0,  0}
    };

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic                 i_tick = 1'b0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [IdxW-1:0]      o_pixel_index;
    logic [ColorW-1:0]    o_pixel_hue;
    logic [ColorW-1:0]    o_pixel_saturation;
    logic [ColorW-1:0]    o_pixel_brightness;
    logic                 o_frame_end;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CfgIdxW-1:0]   i_cfg_index = RegHue;
    logic [ColorW-1:0]    i_cfg_data = 8'd0;

    // Register copies, at their power-on values.
    logic [7:0] hue_set    = 8'd0;
    logic [7:0] sat_set    = 8'd255;
    logic [7:0] bright_set = 8'd255;
    logic [5:0] size_set   = 6'd3;
    logic [7:0] step_set   = 8'd50;
    logic [7:0] turn_set   = 8'd50;

    // Scanner state as the predictor tracks it.
    logic [5:0] eye_at         = 6'd0;
    bit         heading_left   = 1'b1;
    bit         awaiting_first = 1'b1;
    logic [8:0] ticks_left     = 9'd0;

    t_pixel      pixels_due [$];
    int unsigned frames_made = 0;
    int unsigned errors      = 0;
    bit          hold_request = 1'b0;
    bit          steady_run   = 1'b0;

    bouncing_eye_scanner_top #(
        .LED_COUNT(LedCount)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_tick            (i_tick),
        .empty             (empty),
        .pop               (pop),
        .o_pixel_index     (o_pixel_index),
        .o_pixel_hue       (o_pixel_hue),
        .o_pixel_saturation(o_pixel_saturation),
        .o_pixel_brightness(o_pixel_brightness),
        .o_frame_end       (o_frame_end),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // 100 MHz clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One line per mismatch; printing stops after a while but counting does not.
    task automatic report_error(input string msg);
        if (errors < PrintCap) begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
        errors++;
    endtask

    // Queue the pixels of one frame whose left dim pixel sits at first.
    task automatic queue_frame(input int unsigned first, input int unsigned eye_len);
        t_pixel px;
        for (int unsigned i = 0; i < LedCount; i++) begin
            px.index      = i[IdxW-1:0];
            px.frame_last = (i == LedCount - 1);
            if (i == first || i == first + eye_len + 1) begin
                px.hue    = hue_set;
                px.sat    = sat_set;
                px.bright = bright_set / 8'd5;
            end else if (i > first && i <= first + eye_len) begin
                px.hue    = hue_set;
                px.sat    = sat_set;
                px.bright = bright_set;
            end else begin
                px.hue    = 8'd0;
                px.sat    = 8'd0;
                px.bright = 8'd0;
            end
            pixels_due.push_back(px);
        end
    endtask

    // Advance the scanner by one accepted tick; queue its frame when emit is set.
    task automatic scan_tick(input logic t, input bit emit);
        int unsigned eye_len;
        int unsigned top;
        int unsigned pos;
        int unsigned pause;
        bit          sweep_done;
        if (!t) return;
        if (ticks_left != 0) begin
            ticks_left = ticks_left - 9'd1;
            return;
        end
        eye_len = size_set;
        if (eye_len > LedCount - 3) eye_len = LedCount - 3;
        top = LedCount - eye_len - 2;
        if (awaiting_first) begin
            awaiting_first = 1'b0;
            heading_left   = 1'b1;
            eye_at         = top[5:0];
        end
        // Pull the eye back into the range of the current sweep.
        pos = eye_at;
        if (heading_left) begin
            if (pos > top) pos = top;
            if (pos < 1) pos = 1;
        end else if (pos > top - 1) begin
            pos = top - 1;
        end
        if (emit) queue_frame(pos, eye_len);
        frames_made++;
        if (heading_left) begin
            sweep_done = (pos == 1);
            if (sweep_done) begin
                heading_left = 1'b0;
                eye_at       = 6'd0;
            end else begin
                eye_at = 6'(pos - 1);
            end
        end else begin
            sweep_done = (pos == top - 1);
            if (sweep_done) begin
                heading_left = 1'b1;
                eye_at       = top[5:0];
            end else begin
                eye_at = 6'(pos + 1);
            end
        end
        pause = step_set + (sweep_done ? turn_set : 8'd0);
        if (pause < 1) pause = 1;
        ticks_left = 9'(pause - 1);
    endtask

    // Offer one tick, with random gaps, and return after its transfer.
    task automatic send_tick(input logic t);
        while (!steady_run && $urandom_range(99) < IdlePct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_tick <= t;
        do @(posedge i_clk); while (full);
    endtask

    // Stop offering ticks and wait for every pending pixel, then let the pipe empty.
    task automatic settle();
        push <= 1'b0;
        while (pixels_due.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    // Register write, only ever issued with the block idle.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] data);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            RegHue:        hue_set    = data;
            RegSaturation: sat_set    = data;
            RegBrightness: bright_set = data;
            RegEyeSize:    size_set   = data[5:0];
            RegStepDelay:  step_set   = data;
            RegTurnDelay:  turn_set   = data;
            default: ;
        endcase
    endtask

    // Random register write; delays stay short most of the time to keep frames coming.
    task automatic write_random_reg();
        logic [CfgIdxW-1:0] idx;
        logic [7:0]         data;
        idx  = CfgIdxW'($urandom_range(7));
        data = 8'($urandom_range(255));
        if (idx == RegStepDelay || idx == RegTurnDelay) begin
            if ($urandom_range(7) != 0) data = 8'($urandom_range(3));
        end else if (idx == RegEyeSize) begin
            if ($urandom_range(1) != 0) data = 8'($urandom_range(6));
        end
        write_reg(idx, data);
    endtask

    // Compare one pixel transfer with the oldest pending pixel.
    task automatic take_pixel();
        t_pixel want;
        if (pixels_due.size() == 0) begin
            report_error($sformatf("pixel %0d arrived with none pending", o_pixel_index));
            return;
        end
        want = pixels_due.pop_front();
        if (o_pixel_index !== want.index)
            report_error($sformatf("index %0d, want %0d", o_pixel_index, want.index));
        if (o_pixel_hue !== want.hue)
            report_error($sformatf("pixel %0d hue %0d, want %0d",
                                   want.index, o_pixel_hue, want.hue));
        if (o_pixel_saturation !== want.sat)
            report_error($sformatf("pixel %0d saturation %0d, want %0d",
                                   want.index, o_pixel_saturation, want.sat));
        if (o_pixel_brightness !== want.bright)
            report_error($sformatf("pixel %0d brightness %0d, want %0d",
                                   want.index, o_pixel_brightness, want.bright));
        if (o_frame_end !== want.frame_last)
            report_error($sformatf("pixel %0d frame end %b, want %b",
                                   want.index, o_frame_end, want.frame_last));
    endtask

    // Result side: random pops, plus one long hold-off on request.
    initial begin : result_side
        forever begin
            @(posedge i_clk);
            if (pop && !empty) take_pixel();
            if (hold_request) begin
                hold_request = 1'b0;
                pop <= 1'b0;
                repeat (HoldCycles) @(posedge i_clk);
            end else begin
                pop <= i_rst_n && (steady_run || $urandom_range(99) >= IdlePct);
            end
        end
    end

    // Stimulus: reset, directed table, random phases, then wait for the tail.
    initial begin : tick_side
        int unsigned rand_ticks;
        int unsigned phase;
        int unsigned phase_frames;
        logic        t;
        rand_ticks = 0;
        phase      = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[r]) begin
            if (plan[r].kind == RowCfg) begin
                write_reg(plan[r].reg_idx, plan[r].reg_data);
            end else begin
                send_tick(plan[r].tick);
                if (plan[r].typed) begin
                    scan_tick(plan[r].tick, 1'b0);
                    if (plan[r].has_frame) queue_frame(plan[r].first, plan[r].eye_len);
                end else begin
                    scan_tick(plan[r].tick, 1'b1);
                end
            end
        end

        // Random phases: a few register writes, then a burst of ticks.
        while (rand_ticks < RandTicks || frames_made < RandFrames + 8) begin
            repeat ($urandom_range(1, 3)) write_random_reg();
            if (phase == 2) begin
                // Back-to-back frames while the result side holds off fills the block.
                write_reg(RegStepDelay, 8'd0);
                write_reg(RegTurnDelay, 8'd0);
                hold_request = 1'b1;
            end
            steady_run   = (phase == 4);
            phase_frames = frames_made;
            repeat ($urandom_range(20, 60)) begin
                t = ($urandom_range(9) != 0);
                send_tick(t);
                scan_tick(t, 1'b1);
                rand_ticks++;
            end
            if (phase == 2) begin
                while (frames_made < phase_frames + 10) begin
                    send_tick(1'b1);
                    scan_tick(1'b1, 1'b1);
                    rand_ticks++;
                end
            end
            steady_run = 1'b0;
            phase++;
        end

        settle();
        repeat (TailCycles) @(posedge i_clk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin : watchdog
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
